// ===== design/grt_pkg.sv =====
// Shared types and constants of the grid ray tile traversal block.
// No dependencies; every other design file but grt_ram imports this package.
`timescale 1ns / 1ps

package grt_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // Longest run of visited tiles for one ray.
  localparam int unsigned RUN_CAP = 31;

  // Widths that hold the largest supported map (32 x 32 tiles, 256-pixel tiles).
  localparam int unsigned COORD_W = 5;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned REM_W   = 17;
  localparam int unsigned MAG_W   = 15;

  // Sine approximation: den = 5 * 2^30 - 4p.
  localparam logic [33:0] DEN_BASE     = 34'd5368709120;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [15:0] HALF_TURN    = 16'd32768;
  localparam logic [3:0]  LAST_QBIT    = 4'd14;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_INIT,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EMIT
  } back_state_e;

  // One classified command passed from the front to the back.
  typedef struct packed {
    logic               is_cast;
    logic               start_ok;
    logic [3:0]         tile_col;
    logic [3:0]         tile_row;
    logic [7:0]         tile_value;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [REM_W-1:0]   nx;
    logic [REM_W-1:0]   ny;
    logic [MAG_W-1:0]   ax;
    logic [MAG_W-1:0]   ay;
    logic               sx_pos;
    logic               sy_pos;
  } cmd_t;

endpackage

// ===== design/grt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module grt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/grt_cmd_fifo.sv =====
// Short command queue between the front and the back of the traversal block.
// Depends on grt_pkg for the command type.
`timescale 1ns / 1ps

module grt_cmd_fifo
  import grt_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t              buf_q [DEPTH];
  logic [PW-1:0]     wptr_q, rptr_q;
  logic [PW:0]       count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/grt_front.sv =====
// Front of the traversal block: accepts words, works out direction and start tile.
// Depends on grt_pkg; feeds grt_cmd_fifo.
`timescale 1ns / 1ps

module grt_front
  import grt_pkg::*;
#(
  parameter int unsigned MAP_COLS    = 16,
  parameter int unsigned MAP_ROWS    = 16,
  parameter int unsigned TILE_PIXELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_busy_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic        func_i,
  input  logic [3:0]  tile_col_i,
  input  logic [3:0]  tile_row_i,
  input  logic [7:0]  tile_value_i,
  input  logic [17:0] pos_x_i,
  input  logic [17:0] pos_y_i,
  input  logic [15:0] ray_angle_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  localparam int unsigned SPAN = TILE_PIXELS * 256;
  localparam int unsigned TMAX = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;

  front_state_e       state_q, state_d;
  logic               func_q, phase_q;
  logic [3:0]         tc_q, tr_q;
  logic [7:0]         tv_q;
  logic [15:0]        ang_q;
  logic [17:0]        remx_q, remy_q;
  logic [CNT_W-1:0]   cntx_q, cnty_q, iter_q;
  logic [28:0]        p_q;
  logic [33:0]        rem_q, den_q;
  logic [MAG_W-1:0]   quo_q, ax_q, ay_q;
  logic [3:0]         bit_q;

  logic               accept, tile_done, push_ok;
  logic [15:0]        ang_cos;
  logic [14:0]        u;
  logic [33:0]        trial;
  logic               ge;
  logic               sx_pos, sy_pos;

  assign accept    = push_i && !full_o;
  assign full_o    = (state_q != F_IDLE) || clear_busy_i;
  assign tile_done = (iter_q == CNT_W'(TMAX));
  assign push_ok   = (!func_q || tile_done) && !cmd_full_i;
  assign ang_cos   = ang_q + QUARTER_TURN;
  assign u         = phase_q ? ang_q[14:0] : ang_cos[14:0];
  assign trial     = {rem_q[32:0], 1'b0};
  assign ge        = (trial >= den_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (func_i == FUNC_CAST) ? F_MUL : F_PUSH;
        end
      end
      F_MUL:  state_d = F_INIT;
      F_INIT: state_d = F_DIV;
      F_DIV: begin
        if (bit_q == LAST_QBIT) begin
          state_d = phase_q ? F_PUSH : F_MUL;
        end
      end
      F_PUSH: begin
        if (push_ok) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    sx_pos          = !ang_cos[15] && (ax_q != '0);
    sy_pos          = !ang_q[15] && (ay_q != '0);
    cmd_push_o      = (state_q == F_PUSH) && push_ok;
    cmd_o.is_cast   = (func_q == FUNC_CAST);
    cmd_o.start_ok  = (cntx_q < CNT_W'(MAP_COLS)) && (cnty_q < CNT_W'(MAP_ROWS));
    cmd_o.tile_col  = tc_q;
    cmd_o.tile_row  = tr_q;
    cmd_o.tile_value = tv_q;
    cmd_o.cx        = COORD_W'(cntx_q);
    cmd_o.cy        = COORD_W'(cnty_q);
    cmd_o.nx        = sx_pos ? REM_W'(REM_W'(SPAN) - remx_q[REM_W-1:0]) : remx_q[REM_W-1:0];
    cmd_o.ny        = sy_pos ? REM_W'(REM_W'(SPAN) - remy_q[REM_W-1:0]) : remy_q[REM_W-1:0];
    cmd_o.ax        = ax_q;
    cmd_o.ay        = ay_q;
    cmd_o.sx_pos    = sx_pos;
    cmd_o.sy_pos    = sy_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      iter_q  <= CNT_W'(TMAX);
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        iter_q  <= '0;
        phase_q <= 1'b0;
      end else begin
        if (!tile_done) begin
          iter_q <= iter_q + 1'b1;
        end
        if ((state_q == F_DIV) && (bit_q == LAST_QBIT)) begin
          phase_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      tc_q   <= tile_col_i;
      tr_q   <= tile_row_i;
      tv_q   <= tile_value_i;
      ang_q  <= ray_angle_i;
      remx_q <= pos_x_i;
      remy_q <= pos_y_i;
      cntx_q <= '0;
      cnty_q <= '0;
    end else if (!tile_done) begin
      // Start tile by repeated subtraction of the tile span.
      if ((remx_q >= 18'(SPAN)) && (cntx_q != CNT_W'(MAP_COLS))) begin
        remx_q <= remx_q - 18'(SPAN);
        cntx_q <= cntx_q + 1'b1;
      end
      if ((remy_q >= 18'(SPAN)) && (cnty_q != CNT_W'(MAP_ROWS))) begin
        remy_q <= remy_q - 18'(SPAN);
        cnty_q <= cnty_q + 1'b1;
      end
    end

    case (state_q)
      F_MUL: begin
        p_q <= 29'(u * (HALF_TURN - {1'b0, u}));
      end
      F_INIT: begin
        rem_q <= {2'b00, p_q, 3'b000};
        den_q <= DEN_BASE - {3'b000, p_q, 2'b00};
        bit_q <= '0;
      end
      F_DIV: begin
        rem_q <= ge ? (trial - den_q) : trial;
        quo_q <= {quo_q[MAG_W-2:0], ge};
        bit_q <= bit_q + 1'b1;
        if (bit_q == LAST_QBIT) begin
          if (phase_q) begin
            ay_q <= {quo_q[MAG_W-2:0], ge};
          end else begin
            ax_q <= {quo_q[MAG_W-2:0], ge};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/grt_back.sv =====
// Back of the traversal block: owns the tile map, writes tiles and walks rays.
// Depends on grt_pkg and grt_ram; takes commands from grt_cmd_fifo.
`timescale 1ns / 1ps

module grt_back
  import grt_pkg::*;
#(
  parameter int unsigned MAP_COLS    = 16,
  parameter int unsigned MAP_ROWS    = 16,
  parameter int unsigned TILE_PIXELS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  output logic       clear_busy_o,
  input  cmd_t       cmd_i,
  input  logic       cmd_empty_i,
  output logic       cmd_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [3:0] visit_col_o,
  output logic [3:0] visit_row_o,
  output logic       wall_hit_o,
  output logic       last_visit_o
);

  localparam int unsigned SPAN  = TILE_PIXELS * 256;
  localparam int unsigned DEPTH = MAP_COLS * MAP_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAP_COLS);
  localparam int unsigned RW    = $clog2(MAP_ROWS);
  localparam int unsigned MAXD  = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;
  localparam int unsigned NW    = $clog2((MAXD + 2) * SPAN);
  localparam int unsigned PW    = NW + MAG_W;

  back_state_e      state_q, state_d;
  logic [AW-1:0]    clr_q;
  logic [CW-1:0]    cx_q;
  logic [RW-1:0]    cy_q;
  logic [NW-1:0]    nx_q, ny_q;
  logic [MAG_W-1:0] ax_q, ay_q;
  logic             sx_q, sy_q;
  logic [4:0]       n_q;
  logic [PW-1:0]    prodx_q, prody_q;
  logic             ovalid_q;
  logic [3:0]       ocol_q, orow_q;
  logic             owall_q, olast_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       wdata, rdata;
  logic             wr_in_map;
  logic             out_free, emit, wall, step_x, leaving, last;

  grt_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr     = AW'(cy_q * MAP_COLS + cx_q);
  assign wr_in_map = ({2'b00, cmd_i.tile_col} < 6'(MAP_COLS))
                  && ({2'b00, cmd_i.tile_row} < 6'(MAP_ROWS));
  assign out_free  = !ovalid_q || pop_i;
  assign emit      = (state_q == B_EMIT) && out_free;
  assign wall      = !rdata[7];

  always_comb begin
    if (ax_q == '0) begin
      step_x = 1'b0;
    end else if (ay_q == '0) begin
      step_x = 1'b1;
    end else begin
      step_x = (prodx_q < prody_q);
    end
    if (step_x) begin
      leaving = sx_q ? (cx_q == CW'(MAP_COLS - 1)) : (cx_q == '0);
    end else begin
      leaving = sy_q ? (cy_q == RW'(MAP_ROWS - 1)) : (cy_q == '0);
    end
    last = wall || leaving || (n_q == 5'(RUN_CAP - 1));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!cmd_empty_i && cmd_i.is_cast && cmd_i.start_ok) begin
          state_d = B_READ;
        end
      end
      B_READ: state_d = B_EMIT;
      B_EMIT: begin
        if (emit) begin
          state_d = last ? B_IDLE : B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clear_busy_o = (state_q == B_CLEAR);
    cmd_pop_o    = (state_q == B_IDLE) && !cmd_empty_i;
    we           = 1'b0;
    waddr        = clr_q;
    wdata        = 8'hFF;
    case (state_q)
      B_CLEAR: begin
        we = 1'b1;
      end
      B_IDLE: begin
        we    = !cmd_empty_i && !cmd_i.is_cast && wr_in_map;
        waddr = AW'(cmd_i.tile_row * MAP_COLS + cmd_i.tile_col);
        wdata = cmd_i.tile_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        cx_q <= CW'(cmd_i.cx);
        cy_q <= RW'(cmd_i.cy);
        nx_q <= NW'(cmd_i.nx);
        ny_q <= NW'(cmd_i.ny);
        ax_q <= cmd_i.ax;
        ay_q <= cmd_i.ay;
        sx_q <= cmd_i.sx_pos;
        sy_q <= cmd_i.sy_pos;
        n_q  <= '0;
      end
      B_READ: begin
        prodx_q <= PW'(nx_q * ay_q);
        prody_q <= PW'(ny_q * ax_q);
      end
      B_EMIT: begin
        if (emit) begin
          ocol_q  <= 4'(cx_q);
          orow_q  <= 4'(cy_q);
          owall_q <= wall;
          olast_q <= last;
          n_q     <= n_q + 1'b1;
          if (step_x) begin
            cx_q <= sx_q ? cx_q + 1'b1 : cx_q - 1'b1;
            nx_q <= nx_q + NW'(SPAN);
          end else begin
            cy_q <= sy_q ? cy_q + 1'b1 : cy_q - 1'b1;
            ny_q <= ny_q + NW'(SPAN);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign empty_o      = !ovalid_q;
  assign visit_col_o  = ocol_q;
  assign visit_row_o  = orow_q;
  assign wall_hit_o   = owall_q;
  assign last_visit_o = olast_q;

endmodule

// ===== design/grid_ray_tile_traversal_top.sv =====
// Top level of the grid ray tile traversal block.
// Depends on grt_pkg, grt_front, grt_cmd_fifo, grt_back and grt_ram.
`timescale 1ns / 1ps

// Usage
// The input channel is a queue: a word is taken at a clock edge with push
// high and full low. A word with func_i low writes one tile of the map
// (writes outside the map are dropped); a word with func_i high casts a ray
// from pos_x_i/pos_y_i at ray_angle_i and yields one result word for every
// tile the ray visits, the last of them flagged by last_visit_o.
// The result channel is a queue too: while empty is low the oldest result
// is on the result ports, and it is taken at an edge with pop high.
// The front sets up a cast with two 15-step sine divisions, the start-tile
// search running alongside, and passes a tile write on without setup. The
// back handles each visited tile in two states: B_READ for the map read and
// the two side-distance products, B_EMIT to compare and step, which waits
// while the last result is not yet taken. The front can prepare the next
// word while the back is still walking, through a two-deep queue.
// After reset the map is swept to empty, one tile a cycle, through all
// MAP_COLS*MAP_ROWS tiles, during which full stays high.
// If the receiver holds off pop the walk pauses with its current tile; the
// front accepts words until the queue is full and it holds one more itself.

module grid_ray_tile_traversal_top
  import grt_pkg::*;
#(
  parameter int unsigned MAP_COLS    = 16,
  parameter int unsigned MAP_ROWS    = 16,
  parameter int unsigned TILE_PIXELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [3:0]  tile_col_i,
  input  logic [3:0]  tile_row_i,
  input  logic [7:0]  tile_value_i,
  input  logic [17:0] pos_x_i,
  input  logic [17:0] pos_y_i,
  input  logic [15:0] ray_angle_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  visit_col_o,
  output logic [3:0]  visit_row_o,
  output logic        wall_hit_o,
  output logic        last_visit_o
);

  cmd_t f_cmd, b_cmd;
  logic f_push, q_full, q_empty, b_pop, clear_busy;

  grt_front #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_i (clear_busy),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .tile_col_i   (tile_col_i),
    .tile_row_i   (tile_row_i),
    .tile_value_i (tile_value_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .ray_angle_i  (ray_angle_i),
    .cmd_push_o   (f_push),
    .cmd_o        (f_cmd),
    .cmd_full_i   (q_full)
  );

  grt_cmd_fifo #(
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .cmd_o   (b_cmd),
    .empty_o (q_empty)
  );

  grt_back #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_busy_o (clear_busy),
    .cmd_i        (b_cmd),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (b_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .visit_col_o  (visit_col_o),
    .visit_row_o  (visit_row_o),
    .wall_hit_o   (wall_hit_o),
    .last_visit_o (last_visit_o)
  );

endmodule
